/* hdl/csp_pkg.sv */
// Package for the CSV stream parser: request, result and queue entry types,
// result and error codes, register indexes and reset values.
// No dependencies.
package csp_pkg;

	localparam int unsigned CSP_COUNT_WIDTH  = 24;
	localparam int unsigned CSP_OFFSET_WIDTH = 32;
	localparam int unsigned CSP_QUEUE_DEPTH  = 4;

	localparam logic [7:0]  BYTE_LF = 8'h0A;
	localparam logic [7:0]  BYTE_CR = 8'h0D;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam logic [2:0] KIND_DATA      = 3'd0;
	localparam logic [2:0] KIND_FIELD_END = 3'd1;
	localparam logic [2:0] KIND_ROW_END   = 3'd2;
	localparam logic [2:0] KIND_DONE      = 3'd3;
	localparam logic [2:0] KIND_ERROR     = 3'd4;

	localparam logic [1:0] ERR_FIELDS  = 2'd0;
	localparam logic [1:0] ERR_ROWS    = 2'd1;
	localparam logic [1:0] ERR_UNTERM  = 2'd2;

	localparam logic [1:0] REG_DELIMITER  = 2'd0;
	localparam logic [1:0] REG_QUOTE      = 2'd1;
	localparam logic [1:0] REG_ITEM_LIMIT = 2'd2;

	localparam logic [7:0]  DELIMITER_RESET  = 8'd44;
	localparam logic [7:0]  QUOTE_RESET      = 8'd34;
	localparam logic [23:0] ITEM_LIMIT_RESET = 24'd1048576;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} csp_req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  out_byte;
		logic [1:0]  error_code;
		logic [31:0] err_pos;
		logic        run_last;
	} csp_res_t;

	// One queue entry: the final result of an input, preceded by a row end
	// when two_results is set.
	typedef struct packed {
		logic        two_results;
		logic [2:0]  result_kind;
		logic [7:0]  out_byte;
		logic [1:0]  error_code;
		logic [31:0] err_pos;
	} csp_cmd_t;

endpackage

/* hdl/csp_front.sv */
// Front end of the CSV stream parser: configuration registers, quote, row and
// offset state, and classification of each request into a queue entry.
// Depends on csp_pkg.
module csp_front import csp_pkg::*; #(
	parameter int unsigned COUNT_WIDTH  = CSP_COUNT_WIDTH,
	parameter int unsigned OFFSET_WIDTH = CSP_OFFSET_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  csp_req_t    in_req,
	input  logic        queue_full,
	output logic        push,
	output csp_cmd_t    cmd
);

	localparam int unsigned CW = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;
	localparam int unsigned PW = (OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32;

	logic [7:0]              delimiter_q;
	logic [7:0]              quote_q;
	logic [23:0]             limit_q;

	logic                    inside_quotes_q, inside_quotes_d;
	logic                    quote_pending_q, quote_pending_d;
	logic                    cr_pending_q, cr_pending_d;
	logic                    field_has_bytes_q, field_has_bytes_d;
	logic [COUNT_WIDTH-1:0]  fields_q, fields_d;
	logic [COUNT_WIDTH-1:0]  rows_q, rows_d;
	logic [OFFSET_WIDTH-1:0] position_q, position_d;
	logic [OFFSET_WIDTH-1:0] quote_position_q, quote_position_d;
	logic                    halted_q, halted_d;

	logic                    accept;
	logic                    emit;
	logic                    do_outside;
	logic [7:0]              c;
	logic [COUNT_WIDTH-1:0]  fields_inc;
	logic [CW-1:0]           limit_ext;
	logic [PW-1:0]           pos_ext;
	logic [PW-1:0]           quote_pos_ext;

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	assign c         = in_req.data_byte;
	assign limit_ext = CW'(limit_q);
	assign pos_ext   = PW'(position_q);
	assign quote_pos_ext = PW'(quote_position_q);
	assign fields_inc = (fields_q != '1) ? fields_q + COUNT_WIDTH'(1) : fields_q;

	always_comb begin
		inside_quotes_d   = inside_quotes_q;
		quote_pending_d   = quote_pending_q;
		cr_pending_d      = cr_pending_q;
		field_has_bytes_d = field_has_bytes_q;
		fields_d          = fields_q;
		rows_d            = rows_q;
		position_d        = position_q;
		quote_position_d  = quote_position_q;
		halted_d          = halted_q;
		emit              = 1'b0;
		do_outside        = 1'b0;
		cmd               = '0;
		if (in_req.req_type == REQ_END) begin
			if (!halted_q) begin
				emit = 1'b1;
				cmd.two_results = field_has_bytes_q || (fields_q != '0);
				if (inside_quotes_q && !quote_pending_q) begin
					cmd.result_kind  = KIND_ERROR;
					cmd.error_code   = ERR_UNTERM;
					cmd.err_pos      = quote_pos_ext[31:0];
				end else begin
					cmd.result_kind = KIND_DONE;
				end
			end
			inside_quotes_d   = 1'b0;
			quote_pending_d   = 1'b0;
			cr_pending_d      = 1'b0;
			field_has_bytes_d = 1'b0;
			fields_d          = '0;
			rows_d            = '0;
			position_d        = '0;
			quote_position_d  = '0;
			halted_d          = 1'b0;
		end else if (!halted_q) begin
			if (position_q != '1) begin
				position_d = position_q + OFFSET_WIDTH'(1);
			end
			if (quote_pending_q) begin
				quote_pending_d = 1'b0;
				if (c == quote_q) begin
					field_has_bytes_d = 1'b1;
					emit = 1'b1;
					cmd.result_kind = KIND_DATA;
					cmd.out_byte    = c;
				end else begin
					inside_quotes_d = 1'b0;
					do_outside = 1'b1;
				end
			end else if (inside_quotes_q) begin
				if (c == quote_q) begin
					quote_pending_d = 1'b1;
				end else begin
					field_has_bytes_d = 1'b1;
					emit = 1'b1;
					cmd.result_kind = KIND_DATA;
					cmd.out_byte    = c;
				end
			end else if (cr_pending_q) begin
				cr_pending_d = 1'b0;
				do_outside = (c != BYTE_LF);
			end else begin
				do_outside = 1'b1;
			end

			if (do_outside) begin
				priority if (c == quote_q) begin
					inside_quotes_d  = 1'b1;
					quote_position_d = position_q;
				end else if (c == delimiter_q) begin
					fields_d = fields_inc;
					field_has_bytes_d = 1'b0;
					emit = 1'b1;
					if (CW'(fields_inc) >= limit_ext) begin
						cmd.result_kind  = KIND_ERROR;
						cmd.error_code   = ERR_FIELDS;
						cmd.err_pos      = pos_ext[31:0];
						halted_d = 1'b1;
					end else begin
						cmd.result_kind = KIND_FIELD_END;
					end
				end else if (c == BYTE_CR || c == BYTE_LF) begin
					emit = 1'b1;
					if (CW'(rows_q) >= limit_ext) begin
						cmd.result_kind  = KIND_ERROR;
						cmd.error_code   = ERR_ROWS;
						cmd.err_pos      = pos_ext[31:0];
						halted_d = 1'b1;
					end else begin
						if (rows_q != '1) begin
							rows_d = rows_q + COUNT_WIDTH'(1);
						end
						fields_d = '0;
						field_has_bytes_d = 1'b0;
						cmd.result_kind = KIND_ROW_END;
						cr_pending_d = (c == BYTE_CR);
					end
				end else begin
					field_has_bytes_d = 1'b1;
					emit = 1'b1;
					cmd.result_kind = KIND_DATA;
					cmd.out_byte    = c;
				end
			end
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIMITER_RESET;
			quote_q     <= QUOTE_RESET;
			limit_q     <= ITEM_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DELIMITER:  delimiter_q <= cfg_wdata[7:0];
				REG_QUOTE:      quote_q     <= cfg_wdata[7:0];
				REG_ITEM_LIMIT: limit_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_quotes_q   <= 1'b0;
			quote_pending_q   <= 1'b0;
			cr_pending_q      <= 1'b0;
			field_has_bytes_q <= 1'b0;
			fields_q          <= '0;
			rows_q            <= '0;
			position_q        <= '0;
			quote_position_q  <= '0;
			halted_q          <= 1'b0;
		end else if (accept) begin
			inside_quotes_q   <= inside_quotes_d;
			quote_pending_q   <= quote_pending_d;
			cr_pending_q      <= cr_pending_d;
			field_has_bytes_q <= field_has_bytes_d;
			fields_q          <= fields_d;
			rows_q            <= rows_d;
			position_q        <= position_d;
			quote_position_q  <= quote_position_d;
			halted_q          <= halted_d;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		quote_pending_q |-> inside_quotes_q)
		else $error("Pending quote seen outside a quoted field.");
	assert property (@(posedge clk) disable iff (!arst_n)
		cr_pending_q |-> !inside_quotes_q && !halted_q)
		else $error("Pending carriage return inside quotes or after an error.");
`endif

endmodule

/* hdl/csp_fifo.sv */
// Short queue of result entries between the parser front end and the
// result sequencer.
// Depends on csp_pkg.
module csp_fifo import csp_pkg::*; #(
	parameter int unsigned DEPTH = CSP_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  csp_cmd_t push_cmd,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output csp_cmd_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	csp_cmd_t           entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("Queue written while full.");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("Queue read while empty.");
`endif

endmodule

/* hdl/csp_back.sv */
// Result sequencer of the CSV stream parser: expands each queue entry into
// one or two results and holds them in the output register.
// Depends on csp_pkg.
module csp_back import csp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  csp_cmd_t head,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output csp_res_t out_res
);

	logic     out_valid_q;
	csp_res_t out_res_q;
	logic     first_done_q;
	logic     load;
	logic     split;

	assign load  = !out_valid_q || out_ready;
	assign split = head.two_results && !first_done_q;
	assign pop   = load && !empty && !split;

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_res_q    <= '0;
			first_done_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				if (split) begin
					out_res_q              <= '{result_kind: KIND_ROW_END, default: '0};
					first_done_q           <= 1'b1;
				end else begin
					out_res_q.result_kind  <= head.result_kind;
					out_res_q.out_byte     <= head.out_byte;
					out_res_q.error_code   <= head.error_code;
					out_res_q.err_pos      <= head.err_pos;
					out_res_q.run_last     <= 1'b1;
					first_done_q           <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		first_done_q |-> out_valid_q && out_res_q.result_kind == KIND_ROW_END
			&& !out_res_q.run_last)
		else $error("Split entry without its leading row end on the output.");
`endif

endmodule

/* hdl/csv_stream_parser.sv */
// Top level of the CSV stream parser: front end, result queue and result
// sequencer. Depends on csp_pkg, csp_front, csp_fifo and csp_back.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      in_valid / in_ready          in_req (csp_req_t)
//   out       output     out_valid / out_ready        out_res (csp_res_t)
//   cfg       input      cfg_wr_en, no back pressure  cfg_index, cfg_wdata
//
// A request is accepted every cycle while the queue has room; the front end
// updates its state in the cycle of acceptance.
// Each result loads into the output register from the queue head while that
// register is empty or being read; an end marker that closes a row gives a
// row end, then its final result; the output port sets one result per cycle.
// While the output is stalled, the output register and the queue take up to
// QUEUE_DEPTH + 1 entries; a full queue then stalls every request.
// Reset clears all parser state and loads the register defaults.
module csv_stream_parser import csp_pkg::*; #(
	parameter int unsigned COUNT_WIDTH  = CSP_COUNT_WIDTH,
	parameter int unsigned OFFSET_WIDTH = CSP_OFFSET_WIDTH,
	parameter int unsigned QUEUE_DEPTH  = CSP_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  csp_req_t    in_req,
	output logic        out_valid,
	input  logic        out_ready,
	output csp_res_t    out_res
);

	logic     push;
	logic     pop;
	logic     queue_full;
	logic     queue_empty;
	csp_cmd_t push_cmd;
	csp_cmd_t head_cmd;

	csp_front #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.queue_full(queue_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	csp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (queue_full),
		.empty   (queue_empty),
		.head    (head_cmd)
	);

	csp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (queue_empty),
		.head     (head_cmd),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

endmodule
